/* src/sva_pkg.sv */
// Shared types and codes for the sound voice channel allocator.
package sva_pkg;

    localparam int MAX_CHANNELS_DEF = 32;
    localparam logic [5:0] ACTIVE_RESET = 6'd8;

    typedef enum logic [2:0] {
        OP_START       = 3'd0,
        OP_STOP_ORIGIN = 3'd1,
        OP_STOP_SOUND  = 3'd2,
        OP_STOP_ALL    = 3'd3,
        OP_UNLINK      = 3'd4,
        OP_FINISHED    = 3'd5
    } op_t;

    localparam logic [1:0] ST_ASSIGNED = 2'd0;
    localparam logic [1:0] ST_REJECTED = 2'd1;
    localparam logic [1:0] ST_CHANGED  = 2'd2;
    localparam logic [1:0] ST_NOMATCH  = 2'd3;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_ASSIGN,
        ACT_FREE,
        ACT_DETACH,
        ACT_CLEAR
    } act_t;

    typedef struct packed {
        op_t         op;
        logic [9:0]  sound_id;
        logic [15:0] origin_id;
        logic [7:0]  priority_req;
        logic [3:0]  singularity;
        logic [4:0]  channel_index;
    } req_t;

    typedef struct packed {
        logic [1:0] status;
        logic [4:0] channel;
        logic       evicted;
    } res_t;

    typedef struct packed {
        logic [9:0]  sound;
        logic [15:0] origin;
        logic        detached;
        logic [7:0]  prio;
        logic [3:0]  sclass;
    } entry_t;

endpackage

/* src/sound_voice_channel_allocator.sv */
// Sound voice channel allocator: channel table with priority-based start and stop operations.
//
// One operation is handled at a time. A start reads the channel table from channel zero, one
// entry per cycle through the single read port of the table memory, and when every active
// channel is busy and none matches its origin and singularity class, it reads the table a
// second time for an eviction candidate. Stop by origin, stop by sound and unlink with a
// nonzero origin read the table the same way up to the first match; stop all, channel
// finished, unlink with a zero origin and unknown codes skip the table read. A new beat is
// taken while the previous result still waits on the output register.
module sound_voice_channel_allocator import sva_pkg::*; #(
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [5:0]  cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_operation,
    input  logic [9:0]  s_sound_id,
    input  logic [15:0] s_origin_id,
    input  logic [7:0]  s_priority_req,
    input  logic [3:0]  s_singularity,
    input  logic [4:0]  s_channel_index,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [4:0]  m_channel,
    output logic        m_evicted
);

    logic [5:0] active_reg, active_next;
    logic       m_valid_reg, m_valid_next;
    res_t       out_reg, out_next;

    req_t       req;
    res_t       res;
    logic       res_valid, res_ready;

    assign req.op            = op_t'(s_operation);
    assign req.sound_id      = s_sound_id;
    assign req.origin_id     = s_origin_id;
    assign req.priority_req  = s_priority_req;
    assign req.singularity   = s_singularity;
    assign req.channel_index = s_channel_index;

    sva_engine #(.MAX_CHANNELS(MAX_CHANNELS)) u_engine (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .active_channels (active_reg),
        .req_valid       (s_valid),
        .req_ready       (s_ready),
        .req             (req),
        .res_valid       (res_valid),
        .res_ready       (res_ready),
        .res             (res)
    );

    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        active_next  = cfg_wr_en ? cfg_wr_data : active_reg;
        m_valid_next = m_valid_reg;
        out_next     = out_reg;
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
            out_next     = res;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= ACTIVE_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            active_reg  <= active_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_status  = out_reg.status;
    assign m_channel = out_reg.channel;
    assign m_evicted = out_reg.evicted;

endmodule

/* src/sva_chan_ram.sv */
// Channel table memory: one write port, one registered read port.
module sva_chan_ram import sva_pkg::*; #(
    parameter int DEPTH = MAX_CHANNELS_DEF,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  entry_t        wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output entry_t        rd_data
);

    entry_t mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* src/sva_engine.sv */
// Operation sequencer: busy flags, table scans and write-back.
module sva_engine import sva_pkg::*; #(
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
    localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1,
    localparam int CNT_W = $clog2(MAX_CHANNELS + 1)
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [5:0] active_channels,
    input  logic       req_valid,
    output logic       req_ready,
    input  req_t       req,
    output logic       res_valid,
    input  logic       res_ready,
    output res_t       res
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN1  = 4'b0010,
        S_SCAN2  = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

    state_t                  state_reg, state_next;
    logic [MAX_CHANNELS-1:0] busy_reg, busy_next;
    logic                    cmp_valid_reg, cmp_valid_next;
    req_t                    req_reg, req_next;
    logic [CNT_W-1:0]        n_reg, n_next;
    logic [CNT_W-1:0]        addr_reg, addr_next;
    logic [CH_W-1:0]         cmp_idx_reg, cmp_idx_next;
    act_t                    act_reg, act_next;
    logic [CH_W-1:0]         tgt_reg, tgt_next;
    entry_t                  wdata_reg, wdata_next;
    res_t                    res_reg, res_next;

    logic [CNT_W-1:0]        n_cur;
    logic [MAX_CHANNELS-1:0] mask_cur, mask_reg;
    logic [CH_W-1:0]         fin_idx;
    logic                    fin_hit;

    logic                    rd_en, wr_en;
    entry_t                  rd_data;

    logic                    busy_c, org_hit, last, hit, hit_ev;
    act_t                    hit_act;
    entry_t                  hit_wdata;

    sva_chan_ram #(.DEPTH(MAX_CHANNELS)) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (tgt_reg),
        .wr_data (wdata_reg),
        .rd_en   (rd_en),
        .rd_addr (addr_reg[CH_W-1:0]),
        .rd_data (rd_data)
    );

    always_comb begin
        if (active_channels == 6'd0) begin
            n_cur = CNT_W'(1);
        end else if (int'(active_channels) > MAX_CHANNELS) begin
            n_cur = CNT_W'(MAX_CHANNELS);
        end else begin
            n_cur = CNT_W'(active_channels);
        end
    end

    always_comb begin
        for (int i = 0; i < MAX_CHANNELS; i++) begin
            mask_cur[i] = (i < int'(n_cur));
            mask_reg[i] = (i < int'(n_reg));
        end
    end

    assign fin_idx = CH_W'(req.channel_index);
    assign fin_hit = (int'(req.channel_index) < int'(n_cur)) && busy_reg[fin_idx];

    assign busy_c  = busy_reg[cmp_idx_reg];
    assign org_hit = busy_c && !rd_data.detached && (rd_data.origin == req_reg.origin_id);
    assign last    = (CNT_W'(cmp_idx_reg) + CNT_W'(1)) == n_reg;

    always_comb begin
        hit       = 1'b0;
        hit_ev    = 1'b0;
        hit_act   = ACT_NONE;
        hit_wdata = rd_data;
        if (state_reg == S_SCAN2) begin
            if (rd_data.prio >= req_reg.priority_req) begin
                hit     = 1'b1;
                hit_ev  = 1'b1;
                hit_act = ACT_ASSIGN;
            end
        end else begin
            unique case (req_reg.op)
                OP_START: begin
                    if (!busy_c) begin
                        hit     = 1'b1;
                        hit_act = ACT_ASSIGN;
                    end else if (req_reg.origin_id != 16'd0 && org_hit
                                 && rd_data.sclass == req_reg.singularity) begin
                        hit     = 1'b1;
                        hit_ev  = 1'b1;
                        hit_act = ACT_ASSIGN;
                    end
                end
                OP_STOP_ORIGIN: begin
                    if (org_hit) begin
                        hit     = 1'b1;
                        hit_act = ACT_FREE;
                    end
                end
                OP_STOP_SOUND: begin
                    if (busy_c && rd_data.sound == req_reg.sound_id) begin
                        hit     = 1'b1;
                        hit_act = ACT_FREE;
                    end
                end
                OP_UNLINK: begin
                    if (org_hit) begin
                        hit     = 1'b1;
                        hit_act = ACT_DETACH;
                    end
                end
                default: ;
            endcase
        end
        if (hit_act == ACT_ASSIGN) begin
            hit_wdata.sound    = req_reg.sound_id;
            hit_wdata.origin   = req_reg.origin_id;
            hit_wdata.detached = 1'b0;
            hit_wdata.prio     = req_reg.priority_req;
            hit_wdata.sclass   = req_reg.singularity;
        end else begin
            hit_wdata.detached = 1'b1;
        end
    end

    assign req_ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_FINISH);
    assign res       = res_reg;

    always_comb begin
        state_next     = state_reg;
        busy_next      = busy_reg;
        cmp_valid_next = cmp_valid_reg;
        req_next       = req_reg;
        n_next         = n_reg;
        addr_next      = addr_reg;
        cmp_idx_next   = cmp_idx_reg;
        act_next       = act_reg;
        tgt_next       = tgt_reg;
        wdata_next     = wdata_reg;
        res_next       = res_reg;
        rd_en          = 1'b0;
        wr_en          = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (req_valid) begin
                    req_next         = req;
                    n_next           = n_cur;
                    addr_next        = '0;
                    cmp_valid_next   = 1'b0;
                    act_next         = ACT_NONE;
                    res_next.status  = ST_NOMATCH;
                    res_next.channel = 5'd0;
                    res_next.evicted = 1'b0;
                    state_next       = S_FINISH;
                    unique case (req.op)
                        OP_START, OP_STOP_ORIGIN, OP_STOP_SOUND: begin
                            state_next = S_SCAN1;
                        end
                        OP_UNLINK: begin
                            if (req.origin_id != 16'd0) begin
                                state_next = S_SCAN1;
                            end
                        end
                        OP_STOP_ALL: begin
                            act_next = ACT_CLEAR;
                            if (|(busy_reg & mask_cur)) begin
                                res_next.status = ST_CHANGED;
                            end
                        end
                        OP_FINISHED: begin
                            if (fin_hit) begin
                                act_next         = ACT_FREE;
                                tgt_next         = fin_idx;
                                res_next.status  = ST_CHANGED;
                                res_next.channel = req.channel_index;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN1, S_SCAN2: begin
                if (int'(addr_reg) < int'(n_reg)) begin
                    rd_en     = 1'b1;
                    addr_next = addr_reg + CNT_W'(1);
                end
                cmp_valid_next = rd_en;
                cmp_idx_next   = addr_reg[CH_W-1:0];
                if (cmp_valid_reg) begin
                    if (hit) begin
                        state_next       = S_FINISH;
                        cmp_valid_next   = 1'b0;
                        act_next         = hit_act;
                        tgt_next         = cmp_idx_reg;
                        wdata_next       = hit_wdata;
                        res_next.status  = (hit_act == ACT_ASSIGN) ? ST_ASSIGNED : ST_CHANGED;
                        res_next.channel = 5'(cmp_idx_reg);
                        res_next.evicted = hit_ev;
                    end else if (last) begin
                        cmp_valid_next = 1'b0;
                        if (state_reg == S_SCAN1 && req_reg.op == OP_START) begin
                            state_next = S_SCAN2;
                            addr_next  = '0;
                        end else begin
                            state_next      = S_FINISH;
                            act_next        = ACT_NONE;
                            res_next.status = (state_reg == S_SCAN2) ? ST_REJECTED
                                                                     : ST_NOMATCH;
                        end
                    end
                end
            end
            S_FINISH: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                    unique case (act_reg)
                        ACT_ASSIGN: begin
                            wr_en              = 1'b1;
                            busy_next[tgt_reg] = 1'b1;
                        end
                        ACT_FREE: begin
                            busy_next[tgt_reg] = 1'b0;
                        end
                        ACT_DETACH: begin
                            wr_en = 1'b1;
                        end
                        ACT_CLEAR: begin
                            busy_next = busy_reg & ~mask_reg;
                        end
                        default: ;
                    endcase
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            busy_reg      <= '0;
            cmp_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            busy_reg      <= busy_next;
            cmp_valid_reg <= cmp_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg     <= req_next;
        n_reg       <= n_next;
        addr_reg    <= addr_next;
        cmp_idx_reg <= cmp_idx_next;
        act_reg     <= act_next;
        tgt_reg     <= tgt_next;
        wdata_reg   <= wdata_next;
        res_reg     <= res_next;
    end

endmodule

/* tb/sv/tb_sound_voice_channel_allocator.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the sound voice channel allocator with a built-in table predictor.
module tb_sound_voice_channel_allocator;
    import sva_pkg::*;

    localparam int NCH = MAX_CHANNELS_DEF;
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;
    localparam int SETTLE_CYCLES = 2 * NCH + 16;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [9:0]  sound;
        logic [15:0] origin;
        logic [7:0]  prio;
        logic [3:0]  sclass;
        logic [4:0]  index;
    } beat_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [5:0]  cfg_wr_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [2:0]  s_operation = '0;
    logic [9:0]  s_sound_id = '0;
    logic [15:0] s_origin_id = '0;
    logic [7:0]  s_priority_req = '0;
    logic [3:0]  s_singularity = '0;
    logic [4:0]  s_channel_index = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_status;
    logic [4:0]  m_channel;
    logic        m_evicted;

    int src_idle_pct = 0;
    int dst_idle_pct = 0;
    int beats_sent = 0;
    int results_seen = 0;
    int mismatches = 0;
    int sizes_used = 0;
    int n_assigned = 0;
    int n_evicting = 0;
    int n_rejected = 0;
    int n_changed = 0;

    logic       ch_busy [NCH];
    entry_t     ch_entry [NCH];
    logic [5:0] active_cfg;
    res_t       alloc_q [$];

    sound_voice_channel_allocator #(.MAX_CHANNELS(NCH)) u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_sound_id     (s_sound_id),
        .s_origin_id    (s_origin_id),
        .s_priority_req (s_priority_req),
        .s_singularity  (s_singularity),
        .s_channel_index(s_channel_index),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_channel      (m_channel),
        .m_evicted      (m_evicted)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= dst_idle_pct);
    end

    function automatic logic origin_hit(int c, logic [15:0] org);
        return ch_busy[c] && !ch_entry[c].detached && ch_entry[c].origin == org;
    endfunction

    function automatic res_t allocate_predict(beat_t b);
        res_t r;
        int   n;
        int   c;
        int   slot;
        logic ev;
        logic any;
        n = (active_cfg == 6'd0) ? 1 : (active_cfg > NCH) ? NCH : int'(active_cfg);
        r.status = ST_NOMATCH;
        r.channel = 5'd0;
        r.evicted = 1'b0;
        slot = -1;
        ev = 1'b0;
        any = 1'b0;
        case (b.opcode)
            OP_START: begin
                for (c = 0; c < n && slot < 0; c++) begin
                    if (!ch_busy[c]) begin
                        slot = c;
                    end else if (b.origin != 16'd0 && origin_hit(c, b.origin)
                                 && ch_entry[c].sclass == b.sclass) begin
                        slot = c;
                        ev = 1'b1;
                    end
                end
                if (slot < 0) begin
                    for (c = 0; c < n && slot < 0; c++)
                        if (ch_entry[c].prio >= b.prio) slot = c;
                    ev = 1'b1;
                end
                if (slot < 0) begin
                    r.status = ST_REJECTED;
                end else begin
                    ch_busy[slot] = 1'b1;
                    ch_entry[slot].sound = b.sound;
                    ch_entry[slot].origin = b.origin;
                    ch_entry[slot].detached = 1'b0;
                    ch_entry[slot].prio = b.prio;
                    ch_entry[slot].sclass = b.sclass;
                    r.status = ST_ASSIGNED;
                    r.channel = slot[4:0];
                    r.evicted = ev;
                end
            end
            OP_STOP_ORIGIN: begin
                for (c = 0; c < n && slot < 0; c++)
                    if (origin_hit(c, b.origin)) slot = c;
                if (slot >= 0) begin
                    ch_busy[slot] = 1'b0;
                    r.status = ST_CHANGED;
                    r.channel = slot[4:0];
                end
            end
            OP_STOP_SOUND: begin
                for (c = 0; c < n && slot < 0; c++)
                    if (ch_busy[c] && ch_entry[c].sound == b.sound) slot = c;
                if (slot >= 0) begin
                    ch_busy[slot] = 1'b0;
                    r.status = ST_CHANGED;
                    r.channel = slot[4:0];
                end
            end
            OP_STOP_ALL: begin
                for (c = 0; c < n; c++) begin
                    any = any | ch_busy[c];
                    ch_busy[c] = 1'b0;
                end
                if (any) r.status = ST_CHANGED;
            end
            OP_UNLINK: begin
                if (b.origin != 16'd0)
                    for (c = 0; c < n && slot < 0; c++)
                        if (origin_hit(c, b.origin)) slot = c;
                if (slot >= 0) begin
                    ch_entry[slot].detached = 1'b1;
                    r.status = ST_CHANGED;
                    r.channel = slot[4:0];
                end
            end
            OP_FINISHED: begin
                if (int'(b.index) < n && ch_busy[b.index]) begin
                    ch_busy[b.index] = 1'b0;
                    r.status = ST_CHANGED;
                    r.channel = b.index;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic beat_t mk(logic [2:0] op, logic [9:0] snd, logic [15:0] org,
                                 logic [7:0] prio, logic [3:0] sc, logic [4:0] idx);
        beat_t b;
        b.opcode = op;
        b.sound = snd;
        b.origin = org;
        b.prio = prio;
        b.sclass = sc;
        b.index = idx;
        return b;
    endfunction

    function automatic beat_t random_beat();
        beat_t b;
        int    pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)      b.opcode = OP_START;
        else if (pick < 52) b.opcode = OP_STOP_ORIGIN;
        else if (pick < 64) b.opcode = OP_STOP_SOUND;
        else if (pick < 68) b.opcode = OP_STOP_ALL;
        else if (pick < 80) b.opcode = OP_UNLINK;
        else if (pick < 97) b.opcode = OP_FINISHED;
        else if (pick < 99) b.opcode = OP_SPARE_6;
        else                b.opcode = OP_SPARE_7;
        b.sound = ($urandom_range(0, 7) == 0) ? 10'($urandom_range(0, 1023))
                                              : 10'($urandom_range(0, 7));
        b.origin = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 65535))
                                               : 16'($urandom_range(0, 5));
        b.prio = 8'($urandom_range(0, 255));
        b.sclass = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15))
                                               : 4'($urandom_range(0, 2));
        b.index = 5'($urandom_range(0, 31));
        return b;
    endfunction

    task automatic send_beat(input beat_t b);
        res_t want;
        if ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_operation <= b.opcode;
        s_sound_id <= b.sound;
        s_origin_id <= b.origin;
        s_priority_req <= b.prio;
        s_singularity <= b.sclass;
        s_channel_index <= b.index;
        do @(posedge aclk); while (!s_ready);
        want = allocate_predict(b);
        alloc_q.push_back(want);
        beats_sent++;
        case (want.status)
            ST_ASSIGNED: begin
                n_assigned++;
                if (want.evicted) n_evicting++;
            end
            ST_REJECTED: n_rejected++;
            ST_CHANGED:  n_changed++;
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (alloc_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_active(input logic [5:0] count);
        wait_idle();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= count;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        active_cfg = count;
        sizes_used++;
    endtask

    task automatic send_random(input int count);
        int i;
        for (i = 0; i < count; i++) send_beat(random_beat());
    endtask

    task automatic test_directed_ops();
        int i;
        send_beat(mk(OP_START, 10'd1023, 16'd0, 8'd255, 4'd15, 5'd0));
        send_beat(mk(OP_START, 10'd7, 16'd0, 8'd40, 4'd15, 5'd31));
        send_beat(mk(OP_START, 10'd5, 16'd65535, 8'd10, 4'd3, 5'd0));
        send_beat(mk(OP_START, 10'd6, 16'd65535, 8'd20, 4'd3, 5'd0));
        send_beat(mk(OP_START, 10'd8, 16'd65535, 8'd30, 4'd4, 5'd0));
        send_beat(mk(OP_UNLINK, 10'd0, 16'd65535, 8'd0, 4'd0, 5'd0));
        send_beat(mk(OP_START, 10'd9, 16'd65535, 8'd35, 4'd3, 5'd0));
        send_beat(mk(OP_STOP_ORIGIN, 10'd0, 16'd0, 8'd0, 4'd0, 5'd0));
        send_beat(mk(OP_UNLINK, 10'd0, 16'd0, 8'd0, 4'd0, 5'd0));
        send_beat(mk(OP_STOP_SOUND, 10'd6, 16'd0, 8'd0, 4'd0, 5'd0));
        send_beat(mk(OP_STOP_SOUND, 10'd999, 16'd0, 8'd0, 4'd0, 5'd0));
        send_beat(mk(OP_FINISHED, 10'd0, 16'd0, 8'd0, 4'd0, 5'd31));
        send_beat(mk(OP_FINISHED, 10'd0, 16'd0, 8'd0, 4'd0, 5'd0));
        send_beat(mk(OP_FINISHED, 10'd0, 16'd0, 8'd0, 4'd0, 5'd1));
        send_beat(mk(OP_SPARE_6, 10'd1023, 16'd65535, 8'd255, 4'd15, 5'd31));
        send_beat(mk(OP_SPARE_7, 10'd0, 16'd1, 8'd0, 4'd0, 5'd0));
        for (i = 0; i < 6; i++)
            send_beat(mk(OP_START, 10'(20 + i), 16'(100 + i), 8'(50 + i), 4'd1, 5'd0));
        send_beat(mk(OP_START, 10'd40, 16'd200, 8'd255, 4'd0, 5'd0));
        send_beat(mk(OP_START, 10'd41, 16'd201, 8'd53, 4'd0, 5'd0));
        send_beat(mk(OP_START, 10'd42, 16'd202, 8'd0, 4'd0, 5'd0));
        send_beat(mk(OP_STOP_ALL, 10'd0, 16'd0, 8'd0, 4'd0, 5'd0));
        send_beat(mk(OP_STOP_ALL, 10'd0, 16'd0, 8'd0, 4'd0, 5'd0));
    endtask

    task automatic test_active_limits();
        set_active(6'd0);
        send_random(30);
        set_active(6'd1);
        send_random(30);
        set_active(6'd63);
        send_random(40);
        set_active(6'd33);
        send_random(30);
        set_active(6'd32);
        send_random(30);
    endtask

    task automatic test_drain_pause();
        src_idle_pct = 20;
        dst_idle_pct = 50;
        set_active(6'd12);
        send_random(25);
        wait_idle();
        send_random(25);
    endtask

    task automatic test_random_mix(input int src_pct, input int dst_pct);
        src_idle_pct = src_pct;
        dst_idle_pct = dst_pct;
        set_active(6'(NCH));
        send_random(130);
        set_active(ACTIVE_RESET);
        send_random(120);
        set_active(6'($urandom_range(2, NCH - 1)));
        send_random(120);
        set_active(6'($urandom_range(0, 63)));
        send_random(110);
    endtask

    always @(posedge aclk) begin : result_check
        res_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (alloc_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("beat %0d: unexpected result, status %0d channel %0d evicted %0b",
                             results_seen, m_status, m_channel, m_evicted);
            end else begin
                want = alloc_q.pop_front();
                if (m_status !== want.status || m_channel !== want.channel
                    || m_evicted !== want.evicted) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("beat %0d: expected st %0d ch %0d ev %0b, got %0d %0d %0b",
                                 results_seen, want.status, want.channel, want.evicted,
                                 m_status, m_channel, m_evicted);
                end
            end
        end
    end

    initial begin
        int c;
        active_cfg = ACTIVE_RESET;
        for (c = 0; c < NCH; c++) begin
            ch_busy[c] = 1'b0;
            ch_entry[c] = '0;
        end
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed_ops();
        test_active_limits();
        test_drain_pause();
        test_random_mix(34, 78);
        test_random_mix(78, 34);
        test_random_mix(0, 0);
        wait_idle();
        $display("Covered %0d beats over %0d table sizes, with and without idling on both sides",
                 beats_sent, sizes_used);
        $display("Starts: %0d assigned (%0d evicting), %0d rejected; %0d frees or unlinks",
                 n_assigned, n_evicting, n_rejected, n_changed);
        if (mismatches == 0 && alloc_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
